// ===== rtl/owbm_pkg.sv =====
`default_nettype none

package owbm_pkg;

    // Operation codes carried on the input tuser.
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_RESET = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // Register indexes on the configuration port.
    localparam int unsigned REG_RESET_LOW       = 0;
    localparam int unsigned REG_PRESENCE_SAMPLE = 1;
    localparam int unsigned REG_RESET_TAIL      = 2;
    localparam int unsigned REG_SHORT_LOW       = 3;
    localparam int unsigned REG_LONG_LOW        = 4;
    localparam int unsigned REG_READ_SAMPLE     = 5;
    localparam int unsigned REG_SLOT_LENGTH     = 6;
    localparam int unsigned REG_READ_GAP        = 7;
    localparam int unsigned NUM_REGS            = 8;

    localparam int unsigned TIME_W = 10;

    // Fixed timing of the idle tail after a written byte.
    localparam logic [TIME_W-1:0] WRITE_TAIL_TIME = 10'd100;
    localparam logic [2:0]        LAST_BIT        = 3'd7;

    typedef logic [TIME_W-1:0] time_t;

    // One result word.
    typedef struct packed {
        logic       rejected;
        logic [7:0] read_byte;
        logic       presence_seen;
        logic       done_res;
        logic       busy_res;
        logic       drive_low;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/one_wire_bus_master_unit.sv =====
// One-wire bus master: every input word is one microsecond tick.
// The result word of a tick is registered and valid in the cycle after acceptance.
// One input word per cycle unless m_tready stalls; next state is one registered pass.
// Reset: rst_n is asynchronous and active low; the bus returns to idle, the timing
// registers take their default values and the read result and presence flag clear.
`default_nettype none

module one_wire_bus_master_unit
    import owbm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // Input stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] data_byte, [8] line_level, [15:9] zero
    input  wire logic [1:0]  s_tuser,   // [1:0] operation

    // Result stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [0] drive_low, [1] busy_res, [2] done_res,
                                        // [3] presence_seen, [11:4] read_byte,
                                        // [12] rejected, [15:13] zero

    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_RST_LOW  = 3'd1;
    localparam logic [2:0] PH_RST_WAIT = 3'd2;
    localparam logic [2:0] PH_RST_TAIL = 3'd3;
    localparam logic [2:0] PH_SLOT     = 3'd4;
    localparam logic [2:0] PH_GAP      = 3'd5;
    localparam logic [2:0] PH_WTAIL    = 3'd6;

    time_t       cfg_reg [NUM_REGS];

    logic [2:0]  phase_reg, phase_next;
    logic [1:0]  cmd_reg, cmd_next;
    time_t       count_reg, count_next;
    logic [2:0]  bit_reg, bit_next;
    logic [7:0]  shift_reg, shift_next;
    logic        presence_reg, presence_next;
    logic [7:0]  result_byte_reg, result_byte_next;

    logic        out_valid_reg;
    result_t     out_word_reg;
    result_t     word_next;

    logic        in_accept;
    logic [1:0]  op;
    logic [7:0]  data_byte;
    logic        line_level;

    assign op         = s_tuser;
    assign data_byte  = s_tdata[7:0];
    assign line_level = s_tdata[8];

    // The output register frees up whenever its word is taken.
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {3'b000, out_word_reg};

    // Configuration registers.
    assign pready = 1'b1;
    assign prdata = {22'd0, cfg_reg[paddr[4:2]]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[REG_RESET_LOW]       <= 10'd480;
            cfg_reg[REG_PRESENCE_SAMPLE] <= 10'd70;
            cfg_reg[REG_RESET_TAIL]      <= 10'd410;
            cfg_reg[REG_SHORT_LOW]       <= 10'd6;
            cfg_reg[REG_LONG_LOW]        <= 10'd60;
            cfg_reg[REG_READ_SAMPLE]     <= 10'd15;
            cfg_reg[REG_SLOT_LENGTH]     <= 10'd70;
            cfg_reg[REG_READ_GAP]        <= 10'd15;
        end
        else if (psel && penable && pwrite)
        begin
            cfg_reg[paddr[4:2]] <= pwdata[TIME_W-1:0];
        end
    end

    // Next state and result of one tick.
    always_comb
    begin
        logic bitv;
        logic ends;
        time_t low_time;

        phase_next       = phase_reg;
        cmd_next         = cmd_reg;
        count_next       = count_reg;
        bit_next         = bit_reg;
        shift_next       = shift_reg;
        presence_next    = presence_reg;
        result_byte_next = result_byte_reg;
        word_next        = '0;
        bitv             = 1'b0;
        ends             = 1'b0;
        low_time         = '0;

        // Command start, or rejection while a command runs.
        if (phase_reg == PH_IDLE)
        begin
            if (op != OP_TICK)
            begin
                cmd_next   = op;
                count_next = '0;
                bit_next   = '0;
                if (op == OP_RESET)
                begin
                    presence_next = 1'b0;
                    phase_next    = PH_RST_LOW;
                end
                else
                begin
                    shift_next = (op == OP_WRITE) ? data_byte : 8'd0;
                    phase_next = PH_SLOT;
                end
            end
        end
        else if (op != OP_TICK)
        begin
            word_next.rejected = 1'b1;
        end

        if (phase_next != PH_IDLE)
        begin
            word_next.busy_res = 1'b1;
            unique case (phase_next)
                PH_RST_LOW:
                begin
                    word_next.drive_low = 1'b1;
                    ends = ({1'b0, count_next} + 11'd1) >= {1'b0, cfg_reg[REG_RESET_LOW]};
                    if (ends)
                    begin
                        phase_next = PH_RST_WAIT;
                        count_next = '0;
                    end
                    else
                    begin
                        count_next = count_next + 10'd1;
                    end
                end
                PH_RST_WAIT:
                begin
                    ends = ({1'b0, count_next} + 11'd1)
                           >= {1'b0, cfg_reg[REG_PRESENCE_SAMPLE]};
                    if (ends)
                    begin
                        phase_next = PH_RST_TAIL;
                        count_next = '0;
                    end
                    else
                    begin
                        count_next = count_next + 10'd1;
                    end
                end
                PH_RST_TAIL:
                begin
                    // The first tail tick samples the presence pulse.
                    if (count_next == '0)
                    begin
                        presence_next = !line_level;
                    end
                    ends = ({1'b0, count_next} + 11'd1) >= {1'b0, cfg_reg[REG_RESET_TAIL]};
                    if (ends)
                    begin
                        phase_next       = PH_IDLE;
                        count_next       = '0;
                        word_next.done_res = 1'b1;
                    end
                    else
                    begin
                        count_next = count_next + 10'd1;
                    end
                end
                PH_SLOT:
                begin
                    bitv     = shift_next[bit_next];
                    low_time = (cmd_next == OP_WRITE && !bitv) ? cfg_reg[REG_LONG_LOW]
                                                               : cfg_reg[REG_SHORT_LOW];
                    word_next.drive_low = count_next < low_time;
                    if (cmd_next == OP_READ && count_next == cfg_reg[REG_READ_SAMPLE])
                    begin
                        shift_next[bit_next] = shift_next[bit_next] | line_level;
                    end
                    ends = ({1'b0, count_next} + 11'd1)
                           >= {1'b0, cfg_reg[REG_SLOT_LENGTH]};
                    if (ends)
                    begin
                        count_next = '0;
                        if (cmd_next == OP_READ && cfg_reg[REG_READ_GAP] != '0)
                        begin
                            phase_next = PH_GAP;
                        end
                        else if (bit_next != LAST_BIT)
                        begin
                            bit_next   = bit_next + 3'd1;
                            phase_next = PH_SLOT;
                        end
                        else if (cmd_next == OP_WRITE && WRITE_TAIL_TIME != '0)
                        begin
                            phase_next = PH_WTAIL;
                        end
                        else
                        begin
                            if (cmd_next == OP_READ)
                            begin
                                result_byte_next = shift_next;
                            end
                            phase_next         = PH_IDLE;
                            word_next.done_res = 1'b1;
                        end
                    end
                    else
                    begin
                        count_next = count_next + 10'd1;
                    end
                end
                PH_GAP:
                begin
                    ends = ({1'b0, count_next} + 11'd1) >= {1'b0, cfg_reg[REG_READ_GAP]};
                    if (ends)
                    begin
                        count_next = '0;
                        if (bit_next != LAST_BIT)
                        begin
                            bit_next   = bit_next + 3'd1;
                            phase_next = PH_SLOT;
                        end
                        else if (cmd_next == OP_WRITE && WRITE_TAIL_TIME != '0)
                        begin
                            phase_next = PH_WTAIL;
                        end
                        else
                        begin
                            if (cmd_next == OP_READ)
                            begin
                                result_byte_next = shift_next;
                            end
                            phase_next         = PH_IDLE;
                            word_next.done_res = 1'b1;
                        end
                    end
                    else
                    begin
                        count_next = count_next + 10'd1;
                    end
                end
                PH_WTAIL:
                begin
                    ends = ({1'b0, count_next} + 11'd1) >= {1'b0, WRITE_TAIL_TIME};
                    if (ends)
                    begin
                        if (cmd_next == OP_READ)
                        begin
                            result_byte_next = shift_next;
                        end
                        phase_next         = PH_IDLE;
                        count_next         = '0;
                        word_next.done_res = 1'b1;
                    end
                    else
                    begin
                        count_next = count_next + 10'd1;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        word_next.presence_seen = presence_next;
        word_next.read_byte     = result_byte_next;
    end

    // Bus state advances once per accepted tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            cmd_reg         <= OP_TICK;
            count_reg       <= '0;
            bit_reg         <= '0;
            shift_reg       <= '0;
            presence_reg    <= 1'b0;
            result_byte_reg <= '0;
        end
        else if (in_accept)
        begin
            phase_reg       <= phase_next;
            cmd_reg         <= cmd_next;
            count_reg       <= count_next;
            bit_reg         <= bit_next;
            shift_reg       <= shift_next;
            presence_reg    <= presence_next;
            result_byte_reg <= result_byte_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            out_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_word_reg <= word_next;
        end
    end

endmodule

`default_nettype wire
